FILE: sv/rps_pkg.sv
// shared types and constants of the permutation shuffler
`timescale 1ns / 1ps

package rps_pkg;

    // action codes of an input request
    localparam logic [1:0] ACT_RESTART = 2'd0;
    localparam logic [1:0] ACT_SHUFFLE = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] random_word;
        logic [7:0]  read_index;
    } t_in;

    typedef struct packed {
        logic [7:0] element_value;
        logic       shuffle_complete;
        logic       error_flag;
    } t_out;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WAIT_DIV,
        ST_RD_V,
        ST_SWAP_V,
        ST_READ_WAIT,
        ST_FINISH
    } t_state;

endpackage

FILE: sv/rps_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module rps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/rps_divider.sv
// iterative restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module rps_divider #(
    parameter int DW = 16,
    parameter int RW = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [RW-1:0] i_divisor,
    output logic          o_done,
    output logic [RW-1:0] o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_dvd, n_dvd;
    logic [RW-1:0] r_div, n_div;
    logic [RW-1:0] r_rem, n_rem;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_done, n_done;
    logic [RW:0]   trial;

    always_comb begin
        n_dvd  = r_dvd;
        n_div  = r_div;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        trial  = {r_rem, r_dvd[DW-1]};
        if (i_start) begin
            n_dvd = i_dividend;
            n_div = i_divisor;
            n_rem = '0;
            n_cnt = CW'(DW);
        end else if (r_cnt != '0) begin
            // shift in next bit, subtract when it fits
            if (trial >= {1'b0, r_div}) begin
                n_rem = RW'(trial - {1'b0, r_div});
            end else begin
                n_rem = trial[RW-1:0];
            end
            n_dvd  = {r_dvd[DW-2:0], 1'b0};
            n_cnt  = r_cnt - CW'(1);
            n_done = (r_cnt == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: sv/random_permutation_shuffler.sv
// top level: fisher-yates permutation table with shuffle, restart and readout
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_in_data (rps_pkg::t_in)
// out       output     o_out_valid / i_out_ready  o_out_data (rps_pkg::t_out)
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_data (vector_length)
//
// requests: a shuffle request waits on the one-bit-per-cycle remainder unit, a read
//   request on a registered ram read, and a restart on an identity refill of the table
//   (one table entry written per cycle through the single ram write port)
// reset: synchronous, active low; afterwards the table is filled with the identity,
//   and no request is taken during the fill (cfg writes are)
// stalls: one output register; the next request is taken while a result waits,
//   and a finished request holds in its last state until the output register frees

module random_permutation_shuffler #(
    parameter int FIELD_SIZE = 256,
    parameter int WORD_BITS  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rps_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rps_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [7:0]    i_cfg_data
);

    import rps_pkg::*;

    // table address, step counter and index-compare widths
    localparam int AW = $clog2(FIELD_SIZE);
    localparam int SW = $clog2(FIELD_SIZE + 1);
    localparam int IW = (SW > 9) ? SW : 9;

    t_state        r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;       // clear sweep address
    logic          r_pend, n_pend;       // restart request waits for sweep end
    logic [SW-1:0] r_step, n_step;
    logic [7:0]    r_vlen;
    logic [AW-1:0] r_s_val, n_s_val;     // table[step] held for the swap
    logic [AW-1:0] r_v, n_v;             // swap partner index
    logic [7:0]    r_elem, n_elem;
    logic          r_err, n_err;
    t_out          r_out, n_out;
    logic          r_out_valid, n_out_valid;

    // ram port
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [AW-1:0] mem_rdata;

    // remainder unit
    logic          div_start;
    logic          div_done;
    logic [SW-1:0] div_rem;

    logic          in_fire;
    logic [IW-1:0] idx_p1;
    logic          read_ok;
    logic          out_free;

    rps_ram #(
        .WIDTH (AW),
        .DEPTH (FIELD_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rps_divider #(
        .DW (WORD_BITS),
        .RW (SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (WORD_BITS'(i_in_data.random_word)),
        .i_divisor  (r_step + SW'(1)),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // read lands on entry index+1, must stay below both the length and the table
    assign idx_p1  = IW'(i_in_data.read_index) + IW'(1);
    assign read_ok = (i_in_data.read_index < r_vlen) && (idx_p1 < IW'(FIELD_SIZE));

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_pend      = r_pend;
        n_step      = r_step;
        n_s_val     = r_s_val;
        n_v         = r_v;
        n_elem      = r_elem;
        n_err       = r_err;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = r_addr;
        mem_re      = 1'b0;
        mem_raddr   = r_step[AW-1:0];
        div_start   = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                // identity fill, one entry per cycle
                mem_we = 1'b1;
                n_addr = r_addr + AW'(1);
                if (r_addr == AW'(FIELD_SIZE - 1)) begin
                    n_addr  = '0;
                    n_state = r_pend ? ST_FINISH : ST_IDLE;
                    n_pend  = 1'b0;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    n_elem = '0;
                    n_err  = 1'b0;
                    unique case (i_in_data.action)
                        ACT_RESTART: begin
                            n_step  = '0;
                            n_addr  = '0;
                            n_pend  = 1'b1;
                            n_state = ST_CLEAR;
                        end
                        ACT_SHUFFLE: begin
                            if (r_step == SW'(FIELD_SIZE)) begin
                                n_err   = 1'b1;
                                n_state = ST_FINISH;
                            end else begin
                                // fetch table[step] while the remainder runs
                                mem_re    = 1'b1;
                                mem_raddr = r_step[AW-1:0];
                                div_start = 1'b1;
                                n_state   = ST_WAIT_DIV;
                            end
                        end
                        ACT_READ: begin
                            if (read_ok) begin
                                mem_re    = 1'b1;
                                mem_raddr = idx_p1[AW-1:0];
                                n_state   = ST_READ_WAIT;
                            end else begin
                                n_err   = 1'b1;
                                n_state = ST_FINISH;
                            end
                        end
                        default: begin
                            n_err   = 1'b1;
                            n_state = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_WAIT_DIV: begin
                if (div_done) begin
                    n_s_val   = mem_rdata;
                    n_v       = div_rem[AW-1:0];
                    mem_re    = 1'b1;
                    mem_raddr = div_rem[AW-1:0];
                    n_state   = ST_RD_V;
                end
            end
            ST_RD_V: begin
                // table[step] <= table[v]
                mem_we    = 1'b1;
                mem_waddr = r_step[AW-1:0];
                mem_wdata = mem_rdata;
                n_state   = ST_SWAP_V;
            end
            ST_SWAP_V: begin
                // table[v] <= old table[step]
                mem_we    = 1'b1;
                mem_waddr = r_v;
                mem_wdata = r_s_val;
                n_step    = r_step + SW'(1);
                n_state   = ST_FINISH;
            end
            ST_READ_WAIT: begin
                n_elem  = 8'(mem_rdata);
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out.element_value    = r_elem;
                    n_out.shuffle_complete = (r_step == SW'(FIELD_SIZE));
                    n_out.error_flag       = r_err;
                    n_out_valid            = 1'b1;
                    n_state                = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_step      <= '0;
            r_vlen      <= 8'd255;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_vlen <= i_cfg_data;
            end
        end
        r_s_val <= n_s_val;
        r_v     <= n_v;
        r_elem  <= n_elem;
        r_err   <= n_err;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: dv/tb_top.sv
// testbench for the permutation shuffler: table predictor, scoreboard and random traffic
`timescale 1ns / 1ps

module tb_top;
    import rps_pkg::*;

    localparam int FIELD_SIZE      = 256;
    localparam int WORD_BITS       = 16;
    // longest quiet stretch: a restart refill plus a long output stall, taken many times over
    localparam int STALL_LIMIT     = 3000;
    localparam int TARGET_REQUESTS = 1000;
    localparam int PHASES          = 6;

    // scoreboard: own copy of the permutation table, step count and readout length
    class perm_scoreboard;
        logic [7:0] perm_table [FIELD_SIZE];
        logic [8:0] step_count;
        logic [7:0] vector_length;
        t_out       expected_results [$];
        int         mismatches;

        function new();
            refill_identity();
            vector_length = 8'd255;
            mismatches    = 0;
        endfunction

        function void refill_identity();
            for (int i = 0; i < FIELD_SIZE; i++) begin
                perm_table[i] = 8'(i);
            end
            step_count = '0;
        endfunction

        function void set_length(logic [7:0] len);
            vector_length = len;
        endfunction

        // accepted request: update the table and queue the result it must give
        function void note_request(t_in req);
            t_out       res;
            int         s;
            int         v;
            logic [7:0] held;
            res = '0;
            case (req.action)
                ACT_RESTART: begin
                    refill_identity();
                end
                ACT_SHUFFLE: begin
                    if (step_count >= FIELD_SIZE) begin
                        // every position already shuffled
                        res.error_flag = 1'b1;
                    end else begin
                        s    = int'(step_count);
                        v    = int'(req.random_word) % (s + 1);
                        held = perm_table[s];
                        perm_table[s] = perm_table[v];
                        perm_table[v] = held;
                        step_count    = step_count + 9'd1;
                    end
                end
                ACT_READ: begin
                    if (int'(req.read_index) >= int'(vector_length) ||
                        int'(req.read_index) + 1 >= FIELD_SIZE) begin
                        res.error_flag = 1'b1;
                    end else begin
                        // readout vector starts after entry 0
                        res.element_value = perm_table[int'(req.read_index) + 1];
                    end
                end
                default: begin
                    res.error_flag = 1'b1;
                end
            endcase
            res.shuffle_complete = (step_count == FIELD_SIZE);
            expected_results.push_back(res);
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_results.size() == 0) begin
                $error("result with no request pending: element_value %0d", got.element_value);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (got.element_value !== want.element_value) begin
                $error("element_value: expected %0d, actual %0d",
                       want.element_value, got.element_value);
                mismatches++;
            end
            if (got.shuffle_complete !== want.shuffle_complete) begin
                $error("shuffle_complete: expected %0b, actual %0b",
                       want.shuffle_complete, got.shuffle_complete);
                mismatches++;
            end
            if (got.error_flag !== want.error_flag) begin
                $error("error_flag: expected %0b, actual %0b", want.error_flag, got.error_flag);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    // clock, reset and block inputs, all known from time zero
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in        in_data   = '0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data  = '0;

    logic       in_ready;
    logic       out_valid;
    t_out       out_data;
    logic       cfg_ready;

    perm_scoreboard sb;
    int sender_idle_pct   = 26;
    int receiver_idle_pct = 55;
    int sent_count        = 0;
    int quiet_cycles      = 0;

    random_permutation_shuffler #(
        .FIELD_SIZE (FIELD_SIZE),
        .WORD_BITS  (WORD_BITS)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // 20 ns period
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // result check and watchdog on cycles with no handshake at all
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                sb.check_result(out_data);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic t_in make_req(logic [1:0] act, logic [15:0] word, logic [7:0] idx);
        t_in req;
        req.action      = act;
        req.random_word = word;
        req.read_index  = idx;
        return req;
    endfunction

    // mostly in-range read positions, the rest anywhere in the field
    function automatic logic [7:0] read_target();
        if (sb.vector_length != 0 && $urandom_range(3) != 0) begin
            return 8'($urandom_range(int'(sb.vector_length) - 1));
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic t_in random_req(logic [1:0] act);
        return make_req(act, 16'($urandom_range(65535)), read_target());
    endfunction

    // one request: optional random gap, then hold valid until taken
    task automatic push_request(input t_in req);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        sb.note_request(req);
        sent_count++;
    endtask

    // sender holds off until every outstanding result is back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (sb.pending() != 0);
    endtask

    // length write, only while nothing is in flight
    task automatic write_vector_length(input logic [7:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        sb.set_length(len);
    endtask

    // restart, a run of shuffle steps with reads mixed in, then a few reads;
    // a full run goes past completion so late steps are rejected
    task automatic run_shuffle_session(input bit full);
        int n_steps;
        int n_reads;
        n_steps = full ? FIELD_SIZE + $urandom_range(1, 4) : $urandom_range(1, 40);
        push_request(random_req(ACT_RESTART));
        for (int i = 0; i < n_steps; i++) begin
            push_request(random_req(ACT_SHUFFLE));
            if ($urandom_range(9) < 3) begin
                push_request(random_req(ACT_READ));
            end
            // noise: unknown action or a read anywhere, never a restart mid-run
            if ($urandom_range(99) < 2) begin
                push_request(make_req(2'($urandom_range(2, 3)), 16'($urandom_range(65535)),
                                      8'($urandom_range(255))));
            end
        end
        n_reads = $urandom_range(1, 6);
        for (int i = 0; i < n_reads; i++) begin
            push_request(random_req(ACT_READ));
        end
    endtask

    // readout length per phase: the extremes, zero, and mid values
    function automatic logic [7:0] phase_length(int phase);
        case (phase)
            0:       return 8'd255;
            1:       return 8'd1;
            2:       return 8'd0;
            3:       return 8'($urandom_range(2, 254));
            4:       return 8'd128;
            default: return 8'd255;
        endcase
    endfunction

    initial begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: identity readout at both ends, out of range, unknown action
        push_request(make_req(ACT_READ, 16'h0000, 8'd0));
        push_request(make_req(ACT_READ, 16'hffff, 8'd254));
        push_request(make_req(ACT_READ, 16'h0000, 8'd255));
        push_request(make_req(2'd3, 16'hffff, 8'hff));
        // first steps with extreme random words
        push_request(make_req(ACT_SHUFFLE, 16'h0000, 8'd0));
        push_request(make_req(ACT_SHUFFLE, 16'hffff, 8'hff));
        push_request(make_req(ACT_SHUFFLE, 16'hffff, 8'd0));
        push_request(make_req(ACT_SHUFFLE, 16'h8000, 8'd0));
        // reads in the middle of a shuffle, a restart, then a read and a step
        push_request(make_req(ACT_READ, 16'h0000, 8'd0));
        push_request(make_req(ACT_READ, 16'h0000, 8'd1));
        push_request(make_req(ACT_READ, 16'h0000, 8'd2));
        push_request(make_req(ACT_RESTART, 16'hffff, 8'hff));
        push_request(make_req(ACT_READ, 16'h0000, 8'd3));
        push_request(make_req(ACT_SHUFFLE, 16'h5a5a, 8'd0));

        // zero length: every read rejected
        wait_for_results();
        write_vector_length(8'd0);
        push_request(make_req(ACT_READ, 16'h0000, 8'd0));
        push_request(make_req(ACT_READ, 16'h0000, 8'd255));

        // length one: only position zero readable
        wait_for_results();
        write_vector_length(8'd1);
        push_request(make_req(ACT_READ, 16'h0000, 8'd0));
        push_request(make_req(ACT_READ, 16'h0000, 8'd1));
        push_request(make_req(ACT_SHUFFLE, 16'h1234, 8'd0));
        push_request(make_req(ACT_READ, 16'h0000, 8'd0));

        // random phases: idle mix changes every two phases, phases one and three run to
        // completion; each phase tops up the running total to its share of the target
        for (int p = 0; p < PHASES; p++) begin
            wait_for_results();
            case (p / 2)
                0: begin
                    sender_idle_pct   = 26;
                    receiver_idle_pct = 55;
                end
                1: begin
                    sender_idle_pct   = 55;
                    receiver_idle_pct = 26;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            write_vector_length(phase_length(p));
            run_shuffle_session(p == 1 || p == 3);
            while (sent_count < (p + 1) * TARGET_REQUESTS / PHASES) begin
                run_shuffle_session(1'b0);
            end
        end

        // drain, then wait on for stray results
        wait_for_results();
        repeat (FIELD_SIZE + 8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
